/* design/top_k_score_selector_defines.svh */
// ---------------------------------------------------------------------------
// top_k_score_selector_defines.svh
// Assertion macros shared by the selector's RTL files.
// ---------------------------------------------------------------------------
`ifndef TOP_K_SCORE_SELECTOR_DEFINES_SVH
`define TOP_K_SCORE_SELECTOR_DEFINES_SVH

// Check a same-cycle implication on aclk, held off while aresetn is low.
`define TKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication on aclk, held off while aresetn is low.
`define TKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/tks_pkg.sv */
// ---------------------------------------------------------------------------
// tks_pkg
// Types and fixed constants of the top-k score selector.
// ---------------------------------------------------------------------------
package tks_pkg;

    localparam int SCORE_BITS = 32;
    localparam int WORD_BITS  = 20;
    localparam int RANK_BITS  = 6;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_EXCL_FIRST  = 2'd0;
    localparam logic [1:0] REG_EXCL_SECOND = 2'd1;
    localparam logic [1:0] REG_EXCL_THIRD  = 2'd2;

    typedef logic signed [SCORE_BITS-1:0] score_t;
    typedef logic [WORD_BITS-1:0]         word_t;
    typedef logic [RANK_BITS-1:0]         rank_t;

    typedef struct packed {
        score_t score;
        word_t  word_index;
        logic   final_item;
    } in_word_t;

    typedef struct packed {
        rank_t  rank;
        score_t best_score;
        word_t  best_index;
        logic   filled;
        logic   last_of_list;
    } out_word_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;    // place candidate, push lower entries down
        logic shift_up;  // move every entry one rank up, zero enters at bottom
    } cell_ctrl_t;

endpackage

/* design/tks_cell.sv */
// ---------------------------------------------------------------------------
// tks_cell
// One rank of the list: holds an entry, compares it with the candidate and
// trades entries with its neighbors.
// ---------------------------------------------------------------------------
module tks_cell
    import tks_pkg::*;
#(
    parameter int IDX_W = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  score_t           cand_score,
    input  logic [IDX_W-1:0] cand_index,
    input  score_t           up_score,
    input  logic [IDX_W-1:0] up_index,
    input  logic             up_filled,
    input  logic             up_gt,
    input  score_t           dn_score,
    input  logic [IDX_W-1:0] dn_index,
    input  logic             dn_filled,
    output score_t           score,
    output logic [IDX_W-1:0] index,
    output logic             filled,
    output logic             gt
);

    score_t           score_reg,  score_next;
    logic [IDX_W-1:0] index_reg,  index_next;
    logic             filled_reg, filled_next;

    // Empty ranks hold zero, so only positive candidates ever win a compare
    assign gt = cand_score > score_reg;

    always_comb begin
        score_next  = score_reg;
        index_next  = index_reg;
        filled_next = filled_reg;
        if (ctrl.shift_up) begin
            score_next  = dn_score;
            index_next  = dn_index;
            filled_next = dn_filled;
        end else if (ctrl.insert) begin
            if (up_gt) begin
                score_next  = up_score;
                index_next  = up_index;
                filled_next = up_filled;
            end else if (gt) begin
                score_next  = cand_score;
                index_next  = cand_index;
                filled_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_reg  <= '0;
            index_reg  <= '0;
            filled_reg <= 1'b0;
        end else begin
            score_reg  <= score_next;
            index_reg  <= index_next;
            filled_reg <= filled_next;
        end
    end

    assign score  = score_reg;
    assign index  = index_reg;
    assign filled = filled_reg;

endmodule

/* design/top_k_score_selector.sv */
// ---------------------------------------------------------------------------
// top_k_score_selector
// Keeps the TOP_COUNT best positive scores and their word indices in a row
// of compare-and-shift cells; dumps and clears the list on the final word.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one candidate word per handshake (score, word_index,
//   final_item). Non-final words are taken one per cycle outside a readout; the insertion
//   into the cell row completes at the accepting edge.
//   m_ channel: on a final word the list is read out as TOP_COUNT words,
//   rank 0 first, last_of_list set on rank TOP_COUNT-1. The first readout
//   word is valid once the accepted final word has set the drain state and
//   rank 0 has been loaded into the output register. The row then shifts
//   one rank per cycle toward the output register while m_ready does not
//   stall it; s_ready is low during that readout. A stall on m_ready
//   holds the output word and freezes the row; the next input is taken as
//   soon as the last rank has entered the output register.
//   Excluded indexes live in APB registers at 0x0, 0x4, 0x8; write them only
//   while idle. Reset (aresetn low, synchronous) clears the list, the
//   excluded indexes and any pending readout.
// ---------------------------------------------------------------------------
`include "top_k_score_selector_defines.svh"

module top_k_score_selector
    import tks_pkg::*;
#(
    parameter int TOP_COUNT  = 40,
    parameter int INDEX_BITS = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // candidate words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    // ranked readout words
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    // Index bits actually kept: the field is 20 bits, INDEX_BITS may mask more
    localparam int KEEP_BITS = (INDEX_BITS < WORD_BITS) ? INDEX_BITS : WORD_BITS;

    typedef logic [KEEP_BITS-1:0] kidx_t;

    // ---------------- configuration registers ----------------
    kidx_t excl_first_reg,  excl_first_next;
    kidx_t excl_second_reg, excl_second_next;
    kidx_t excl_third_reg,  excl_third_next;
    logic  cfg_wr;
    logic [1:0] cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[3:2];

    always_comb begin
        excl_first_next  = excl_first_reg;
        excl_second_next = excl_second_reg;
        excl_third_next  = excl_third_reg;
        if (cfg_wr) begin
            case (cfg_sel)
                REG_EXCL_FIRST:  excl_first_next  = KEEP_BITS'(pwdata);
                REG_EXCL_SECOND: excl_second_next = KEEP_BITS'(pwdata);
                REG_EXCL_THIRD:  excl_third_next  = KEEP_BITS'(pwdata);
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_EXCL_FIRST:  prdata = DATA_BITS'(excl_first_reg);
            REG_EXCL_SECOND: prdata = DATA_BITS'(excl_second_reg);
            REG_EXCL_THIRD:  prdata = DATA_BITS'(excl_third_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    logic       s_accept;
    kidx_t      cand_index;
    logic       excluded;
    cell_ctrl_t cell_ctrl;

    logic  drain_reg, drain_next;
    rank_t cnt_reg,   cnt_next;
    logic  load;

    assign s_ready    = !drain_reg;
    assign s_accept   = s_valid && s_ready;
    assign cand_index = KEEP_BITS'(s_data.word_index);
    assign excluded   = (cand_index == excl_first_reg) ||
                        (cand_index == excl_second_reg) ||
                        (cand_index == excl_third_reg);

    // Readout advances whenever the output register is free or being emptied
    assign load = drain_reg && (!m_valid || m_ready);

    assign cell_ctrl.insert   = s_accept && !excluded;
    assign cell_ctrl.shift_up = load;

    // ---------------- cell row ----------------
    // Element i+1 is the output of cell i; element 0 and TOP_COUNT+1 are the
    // empty neighbors beyond the ends of the row.
    score_t c_score  [0:TOP_COUNT+1];
    kidx_t  c_index  [0:TOP_COUNT+1];
    logic   c_filled [0:TOP_COUNT+1];
    logic   c_gt     [0:TOP_COUNT];

    assign c_score[0]            = '0;
    assign c_index[0]            = '0;
    assign c_filled[0]           = 1'b0;
    assign c_gt[0]               = 1'b0;
    assign c_score[TOP_COUNT+1]  = '0;
    assign c_index[TOP_COUNT+1]  = '0;
    assign c_filled[TOP_COUNT+1] = 1'b0;

    for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
        tks_cell #(
            .IDX_W (KEEP_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .cand_score (s_data.score),
            .cand_index (cand_index),
            .up_score   (c_score[i]),
            .up_index   (c_index[i]),
            .up_filled  (c_filled[i]),
            .up_gt      (c_gt[i]),
            .dn_score   (c_score[i+2]),
            .dn_index   (c_index[i+2]),
            .dn_filled  (c_filled[i+2]),
            .score      (c_score[i+1]),
            .index      (c_index[i+1]),
            .filled     (c_filled[i+1]),
            .gt         (c_gt[i+1])
        );
    end

    // ---------------- readout sequencer and output register ----------------
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg,  m_data_next;
    logic      last_rank;

    assign last_rank = (cnt_reg == RANK_BITS'(TOP_COUNT - 1));

    always_comb begin
        drain_next   = drain_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            // Take rank 0 of the row; the row shifts up at the same edge
            m_valid_next             = 1'b1;
            m_data_next.rank         = cnt_reg;
            m_data_next.best_score   = c_score[1];
            m_data_next.best_index   = WORD_BITS'(c_index[1]);
            m_data_next.filled       = c_filled[1];
            m_data_next.last_of_list = last_rank;
            if (last_rank) begin
                drain_next = 1'b0;
                cnt_next   = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (s_accept && s_data.final_item) begin
            // Start readout after this final candidate has been placed
            drain_next = 1'b1;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            excl_first_reg  <= '0;
            excl_second_reg <= '0;
            excl_third_reg  <= '0;
            drain_reg       <= 1'b0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            excl_first_reg  <= excl_first_next;
            excl_second_reg <= excl_second_next;
            excl_third_reg  <= excl_third_next;
            drain_reg       <= drain_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    `TKS_ASSERT_NEXT(a_final_starts_drain, s_accept && s_data.final_item,
        drain_reg && (cnt_reg == '0), "final word did not start readout at rank 0")
    `TKS_ASSERT_NEXT(a_last_rank_ends_drain, load && last_rank,
        !drain_reg, "readout continued past the last rank")
    `TKS_ASSERT_NOW(a_no_insert_in_drain, drain_reg,
        !cell_ctrl.insert, "insertion during readout")
    `TKS_ASSERT_NOW(a_row_descending, 1'b1,
        c_score[1] >= c_score[2], "top of cell row is out of order")

endmodule

/* bench/top_k_score_selector_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_selector_tb
// Drives candidate words through the selector and checks every ranked word of
// each readout against a software copy of the ranked list. The exclusion
// registers are set over the APB port between phases, reset values first, then
// several settings that include all-zero and all-ones indexes.
// ----------------------------------------------------------------------------
module top_k_score_selector_tb;
    import tks_pkg::*;

    localparam int TOP_COUNT   = 40;
    localparam int INDEX_BITS  = 20;
    localparam int STALL_LIMIT = 4000;  // cycles with no word moving
    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 85;
    // Register slot that the block does not decode
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam word_t INDEX_TOP = '1;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_word_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_word_t            m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // Software copy of the ranked list and of the exclusion registers
    score_t held_score  [TOP_COUNT];
    word_t  held_index  [TOP_COUNT];
    logic   held_filled [TOP_COUNT];
    word_t  excl_first  = '0;
    word_t  excl_second = '0;
    word_t  excl_third  = '0;

    in_word_t  pending_words  [$];  // candidates waiting for the driver
    out_word_t readout_expect [$];  // ranked words still owed by the block

    int unsigned send_idle_pct  = 14;
    int unsigned recv_stall_pct = 14;
    int unsigned mismatches     = 0;
    int unsigned words_taken    = 0;
    int unsigned lists_read     = 0;
    int unsigned ranks_checked  = 0;
    int unsigned settings_used  = 0;
    int unsigned quiet_cycles   = 0;

    top_k_score_selector #(
        .TOP_COUNT (TOP_COUNT),
        .INDEX_BITS(INDEX_BITS)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_held();
        for (int r = 0; r < TOP_COUNT; r++) begin
            held_score[r]  = '0;
            held_index[r]  = '0;
            held_filled[r] = 1'b0;
        end
    endfunction

    // Insert one accepted candidate into the ranked list; on a final word,
    // queue the whole list as ranked words and start over empty.
    function automatic void predict_candidate(in_word_t w);
        int        slot;
        out_word_t o;
        slot = TOP_COUNT;
        if (w.word_index != excl_first && w.word_index != excl_second &&
            w.word_index != excl_third) begin
            // Walk upward so that slot ends on the first rank holding less;
            // an equal score never wins, so ties stay behind older entries.
            for (int r = TOP_COUNT - 1; r >= 0; r--) begin
                if ($signed(w.score) > $signed(held_score[r])) slot = r;
            end
            if (slot < TOP_COUNT) begin
                for (int r = TOP_COUNT - 1; r > slot; r--) begin
                    held_score[r]  = held_score[r-1];
                    held_index[r]  = held_index[r-1];
                    held_filled[r] = held_filled[r-1];
                end
                held_score[slot]  = w.score;
                held_index[slot]  = w.word_index;
                held_filled[slot] = 1'b1;
            end
        end
        if (w.final_item) begin
            for (int r = 0; r < TOP_COUNT; r++) begin
                o.rank         = rank_t'(r);
                o.best_score   = held_score[r];
                o.best_index   = held_index[r];
                o.filled       = held_filled[r];
                o.last_of_list = (r == TOP_COUNT - 1);
                readout_expect.push_back(o);
            end
            clear_held();
            lists_read++;
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_word(score_t sc, word_t idx, logic fin);
        in_word_t w;
        w.score      = sc;
        w.word_index = idx;
        w.final_item = fin;
        pending_words.push_back(w);
    endfunction

    // Write one exclusion register over APB (setup then access cycle), mirror
    // it in the copy, and read it back unless the slot is undecoded.
    task automatic set_exclusion(input logic [1:0] reg_id, input logic [DATA_BITS-1:0] value);
        word_t                stored;
        logic [DATA_BITS-1:0] got;
        stored = value[WORD_BITS-1:0];
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // the write lands at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_id)
            REG_EXCL_FIRST: begin
                excl_first = stored;
            end
            REG_EXCL_SECOND: begin
                excl_second = stored;
            end
            REG_EXCL_THIRD: begin
                excl_third = stored;
            end
            default: begin
            end
        endcase
        if (reg_id != REG_UNUSED) begin
            @(posedge aclk);
            psel <= 1'b1;
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            check_field("exclusion readback", 32'(stored), 32'(got[WORD_BITS-1:0]));
        end
    endtask

    // Hold until every candidate is taken and every ranked word has come back,
    // then let the row settle before touching registers.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_words.size() != 0 || s_valid || readout_expect.size() != 0);
        repeat (2) @(negedge aclk);
    endtask

    // Driver: predict on each accepted word, then present the next pending
    // word or idle. Valid is only dropped once the current word is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_candidate(s_data);
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each ranked word with the oldest owed one, field by
    // field, and stall the result side at random.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (readout_expect.size() == 0) begin
                    $display("%0t: ranked word with none owed, expected nothing, actual %0h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    want = readout_expect.pop_front();
                    check_field("rank", 32'(want.rank), 32'(m_data.rank));
                    check_field("best_score", want.best_score, m_data.best_score);
                    check_field("best_index", 32'(want.best_index), 32'(m_data.best_index));
                    check_field("filled", 32'(want.filled), 32'(m_data.filled));
                    check_field("last_of_list", 32'(want.last_of_list),
                                32'(m_data.last_of_list));
                    ranks_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves on any port for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [DATA_BITS-1:0] cfg [3];
        score_t               sc;
        score_t               prev_score;
        word_t                idx;
        int unsigned          pick;
        int unsigned          list_len;
        int unsigned          phase_words;

        clear_held();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        settings_used++;

        // Reset exclusions are all zero, so index 0 is already shut out.
        queue_word(32'h7FFF_FFFF, INDEX_TOP, 1'b0);      // largest score, top index
        queue_word(32'h8000_0000, 20'h0_0005, 1'b0);     // most negative, dropped
        queue_word(32'h0000_0000, 20'h0_0006, 1'b0);     // zero never enters
        queue_word(32'hFFFF_FFFF, 20'h0_0007, 1'b0);     // minus one lsb
        queue_word(32'h0000_0001, 20'h0_0008, 1'b0);     // smallest positive
        queue_word(32'h0100_0000, 20'h0_0009, 1'b0);     // 1.0
        queue_word(32'h0100_0000, 20'h0_000A, 1'b0);     // tie lands behind
        queue_word(32'h0200_0000, 20'h0_0000, 1'b0);     // excluded index
        queue_word(32'h0080_0000, 20'h5_5555, 1'b1);     // final carries a candidate
        queue_word(32'h0000_0000, 20'hA_AAAA, 1'b1);     // readout of an empty list
        wait_drained();

        // Junk in the upper data bits must be masked off.
        set_exclusion(REG_EXCL_FIRST, 32'hFFFF_FFFF);
        set_exclusion(REG_EXCL_SECOND, 32'hABC1_2345);
        set_exclusion(REG_EXCL_THIRD, 32'h0000_0000);
        // A write to the undecoded slot must not exclude index 1.
        set_exclusion(REG_UNUSED, 32'h0000_0001);
        settings_used++;
        @(negedge aclk);
        queue_word(32'h7FFF_FFFF, INDEX_TOP, 1'b0);      // excluded by first
        queue_word(32'h0000_0005, 20'h0_0000, 1'b0);     // excluded by third
        queue_word(32'h0000_0005, 20'h0_0001, 1'b0);     // admitted
        queue_word(32'h7FFF_FFFE, 20'h1_2344, 1'b0);     // neighbor of an excluded index
        queue_word(32'h7FFF_FFFF, 20'h1_2345, 1'b1);     // excluded final still reads out
        wait_drained();

        // Random phases: lists of random length closed by a final word, most
        // shorter than the list, some long enough to push entries off the end.
        prev_score = 32'h0100_0000;
        for (int p = 0; p < PHASES; p++) begin
            for (int k = 0; k < 3; k++) begin
                case (p)
                    1: begin
                        cfg[k] = '1;
                    end
                    2: begin
                        cfg[k] = $urandom & 32'hFFF0_0000;
                    end
                    3: begin
                        cfg[k] = $urandom_range(63);
                    end
                    default: begin
                        cfg[k] = $urandom;
                    end
                endcase
            end
            set_exclusion(REG_EXCL_FIRST, cfg[0]);
            set_exclusion(REG_EXCL_SECOND, cfg[1]);
            set_exclusion(REG_EXCL_THIRD, cfg[2]);
            settings_used++;
            // One phase runs both sides flat out.
            send_idle_pct  = (p == 1) ? 0 : 14;
            recv_stall_pct = (p == 1) ? 0 : 14;
            @(negedge aclk);

            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                list_len = ($urandom_range(9) == 0) ? $urandom_range(60, 41)
                                                    : $urandom_range(35);
                for (int j = 0; j <= list_len; j++) begin
                    pick = $urandom_range(99);
                    if (pick < 8) begin
                        case ($urandom_range(4))
                            0: sc = 32'h7FFF_FFFF;
                            1: sc = 32'h8000_0000;
                            2: sc = 32'h0000_0000;
                            3: sc = 32'h0000_0001;
                            default: sc = 32'hFFFF_FFFF;
                        endcase
                    end else if (pick < 20) begin
                        sc = prev_score;                       // force a tie
                    end else if (pick < 35) begin
                        sc = $urandom | 32'h8000_0000;         // negative
                    end else if (pick < 60) begin
                        sc = $urandom_range(32'h0400_0000, 1); // crowd at or below 4.0
                    end else begin
                        sc = $urandom & 32'h7FFF_FFFF;
                    end
                    prev_score = sc;

                    pick = $urandom_range(99);
                    if (pick < 12) begin
                        case ($urandom_range(2))
                            0: idx = excl_first;
                            1: idx = excl_second;
                            default: idx = excl_third;
                        endcase
                    end else if (pick < 18) begin
                        idx = ($urandom_range(1) == 0) ? INDEX_TOP : '0;
                    end else if (pick < 45) begin
                        idx = word_t'($urandom_range(63));
                    end else begin
                        idx = word_t'($urandom);
                    end
                    queue_word(sc, idx, j == list_len);
                    phase_words++;
                end
            end
            wait_drained();
        end

        // Let any stray ranked word show up before closing.
        repeat (TOP_COUNT + 8) @(posedge aclk);
        if (readout_expect.size() != 0) begin
            $display("%0t: ranked words still owed, expected 0, actual %0d",
                     $time, readout_expect.size());
            mismatches++;
        end
        $display("Covered %0d candidate words and %0d list readouts, %0d ranked words checked,",
                 words_taken, lists_read, ranks_checked);
        $display("under %0d exclusion settings with idle and stall gaps on both sides.",
                 settings_used);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
